@@ rtl/salc_pkg.sv @@
`default_nettype none

package salc_pkg;

  // Cache geometry.
  localparam int SET_BITS    = 2;
  localparam int WAYS        = 4;
  localparam int OFFSET_BITS = 4;

  // Fixed field widths.
  localparam int ADDR_W = 64;
  localparam int CNT_W  = 32;

  localparam int NUM_SETS = 1 << SET_BITS;
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_W    = ADDR_W - SET_BITS - OFFSET_BITS;
  localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

  // Access kinds carried on the kind field.
  localparam logic KIND_SINGLE = 1'b0;
  localparam logic KIND_MODIFY = 1'b1;

  typedef logic [SET_W-1:0]  set_idx_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [RANK_W-1:0] way_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // One memory row holds everything the tag store keeps for one set.
  typedef struct packed {
    logic [WAYS-1:0]             valid;
    logic [WAYS-1:0][RANK_W-1:0] rank;
    logic [WAYS-1:0][TAG_W-1:0]  tag;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // Outcome of one lookup, passed from the update logic to the controller.
  typedef struct packed {
    logic hit;
    logic evict;
    row_t row;
  } upd_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // Row contents after reset: all ways invalid, ranks equal to the way index.
  function automatic row_t salc_reset_row();
    row_t r;
    r.valid = '0;
    r.tag   = '0;
    for (int w = 0; w < WAYS; w++) begin
      r.rank[w] = rank_t'(w);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/salc_in_if.sv @@
`default_nettype none

interface salc_in_if import salc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output kind, output address, input ready);
  modport sink (input valid, input kind, input address, output ready);
endinterface

`default_nettype wire

@@ rtl/salc_out_if.sv @@
`default_nettype none

interface salc_out_if import salc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             first_hit;
  logic             evicted;
  logic [CNT_W-1:0] hits_total;
  logic [CNT_W-1:0] misses_total;
  logic [CNT_W-1:0] evictions_total;

  modport source (output valid, output first_hit, output evicted, output hits_total,
                  output misses_total, output evictions_total, input ready);
  modport sink (input valid, input first_hit, input evicted, input hits_total,
                input misses_total, input evictions_total, output ready);
endinterface

`default_nettype wire

@@ rtl/set_assoc_lru_cache_tags.sv @@
`default_nettype none

// Channel  Dir  Payload                                              Transfer
// acc      in   kind, address                                        valid && ready
// res      out  first_hit, evicted, hits_total, misses_total,        valid && ready
//               evictions_total
//
// Each access first reads the set's row from the tag RAM, then updates it and writes it
// back; a new access is not taken until that write-back, so accesses do not overlap.
// After reset a clearing pass writes every set row before acc.ready rises.
// A result waits in an output register; a stalled result holds the block in its update
// cycle, and a new access is taken as soon as that result has been committed.
module set_assoc_lru_cache_tags import salc_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  salc_in_if.sink   acc,
  salc_out_if.source res
);

  state_t   state;
  state_t   state_next;
  set_idx_t clr_idx;
  set_idx_t set_q;
  tag_t     tag_q;
  logic     kind_q;
  cnt_t     hit_counter;
  cnt_t     miss_counter;
  cnt_t     evict_counter;

  set_idx_t acc_set;
  tag_t     acc_tag;
  set_idx_t ram_raddr;
  set_idx_t ram_waddr;
  row_t     ram_wdata;
  row_t     ram_rdata;
  logic     ram_we;
  logic     commit;
  upd_t     upd;

  // Split the byte address into set index and tag; the block offset is dropped.
  assign acc_set = set_idx_t'((acc.address >> OFFSET_BITS) & ADDR_W'(NUM_SETS - 1));
  assign acc_tag = tag_t'(acc.address >> (SET_BITS + OFFSET_BITS));

  // The update cycle may finish only when the output register is free or being drained.
  assign commit = (state == ST_LOOKUP) && (!res.valid || res.ready);

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  salc_row_update u_update (
    .row (ram_rdata),
    .tag (tag_q),
    .upd (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state, RAM control and input ready.
  always_comb begin
    state_next = state;
    acc.ready  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = set_q;
    ram_wdata  = upd.row;
    ram_raddr  = set_q;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = salc_reset_row();
        if (clr_idx == set_idx_t'(NUM_SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        acc.ready = 1'b1;
        ram_raddr = acc_set;
        if (acc.valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // While stalled the same row is read again; nothing writes it meanwhile.
        if (commit) begin
          ram_we     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + set_idx_t'(1);
    end
  end

  // Access fields held for the update cycle.
  always_ff @(posedge clk) begin
    if (acc.valid && acc.ready) begin
      set_q  <= acc_set;
      tag_q  <= acc_tag;
      kind_q <= acc.kind;
    end
  end

  // Running totals. A modify adds a second hit for its store half.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter   <= '0;
      miss_counter  <= '0;
      evict_counter <= '0;
    end else if (commit) begin
      hit_counter   <= hit_counter + cnt_t'(upd.hit) + cnt_t'(kind_q);
      miss_counter  <= miss_counter + cnt_t'(!upd.hit);
      evict_counter <= evict_counter + cnt_t'(upd.evict);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (commit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res.first_hit       <= upd.hit;
      res.evicted         <= upd.evict;
      res.hits_total      <= hit_counter + cnt_t'(upd.hit) + cnt_t'(kind_q);
      res.misses_total    <= miss_counter + cnt_t'(!upd.hit);
      res.evictions_total <= evict_counter + cnt_t'(upd.evict);
    end
  end

`ifndef NO_ASSERTIONS
  // The tag RAM is only written by the clearing pass or a committing update.
  a_ram_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == ST_CLEAR) || commit))
    else $error("tag RAM written outside clear or commit");

  // A new result appears only right after an update commits.
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(commit))
    else $error("result raised without a commit");

  // Each item adds one access, plus one more for a modify.
  a_access_count: assert property (@(posedge clk) disable iff (rst)
    commit |=> (hit_counter + miss_counter) ==
               ($past(hit_counter) + $past(miss_counter) + cnt_t'(1) + cnt_t'($past(kind_q))))
    else $error("access totals advanced by the wrong amount");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (commit && upd.hit) |=> (evict_counter == $past(evict_counter)))
    else $error("eviction counted on a hit");
`endif

endmodule

`default_nettype wire

@@ rtl/salc_ram.sv @@
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/salc_row_update.sv @@
`default_nettype none

module salc_row_update import salc_pkg::*; (
  input  wire row_t row,
  input  wire tag_t tag,
  output upd_t      upd
);

  logic            hit;
  logic            any_inv;
  way_t            hit_way;
  way_t            inv_way;
  way_t            lru_way;
  way_t            victim;
  rank_t           vrank;
  row_t            row_new;

  always_comb begin
    hit     = 1'b0;
    any_inv = 1'b0;
    hit_way = '0;
    inv_way = '0;
    lru_way = '0;
    // Scan from the top way down so the lowest-numbered match wins.
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (row.valid[i] && (row.tag[i] == tag)) begin
        hit     = 1'b1;
        hit_way = way_t'(i);
      end
      if (!row.valid[i]) begin
        any_inv = 1'b1;
        inv_way = way_t'(i);
      end
      if (row.rank[i] == rank_t'(WAYS - 1)) begin
        lru_way = way_t'(i);
      end
    end

    priority if (hit) begin
      victim = hit_way;
    end else if (any_inv) begin
      victim = inv_way;
    end else begin
      victim = lru_way;
    end

    // Promote the chosen way to most recent and age the ways more recent than it.
    vrank   = row.rank[victim];
    row_new = row;
    for (int i = 0; i < WAYS; i++) begin
      if (row.rank[i] < vrank) begin
        row_new.rank[i] = row.rank[i] + rank_t'(1);
      end
    end
    row_new.rank[victim]  = '0;
    row_new.valid[victim] = 1'b1;
    row_new.tag[victim]   = tag;

    upd.hit   = hit;
    upd.evict = !hit && !any_inv;
    upd.row   = row_new;
  end

endmodule

`default_nettype wire

@@ verif/salc_checker.sv @@
`default_nettype none

// Watches both channels, keeps its own copy of the tag store and the running totals,
// and compares every result transfer with the oldest outstanding prediction.
module salc_checker import salc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  salc_in_if                acc,
  salc_out_if               res,
  output int unsigned       fail_count,
  output int unsigned       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic first_hit;
    logic evicted;
    cnt_t hits;
    cnt_t misses;
    cnt_t evicts;
  } access_outcome_t;

  typedef logic bool_found_t;

  // Shadow tag store: age 0 is the most recent way of a set.
  logic  way_valid [NUM_SETS][WAYS];
  tag_t  way_tag   [NUM_SETS][WAYS];
  rank_t way_age   [NUM_SETS][WAYS];
  cnt_t  hit_sum, miss_sum, evict_sum;

  access_outcome_t outcome_q[$];
  int unsigned     mismatches = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic promote_way(input int s, input int w);
    rank_t prior;
    prior = way_age[s][w];
    for (int i = 0; i < WAYS; i++) begin
      if (way_age[s][i] < prior) way_age[s][i] = way_age[s][i] + 1'b1;
    end
    way_age[s][w] = '0;
  endtask

  // One lookup in the shadow store, with refill on a miss.
  task automatic lookup_way(input tag_t t, input int s, output logic hit, inout logic ev);
    int  victim;
    bool_found_t found;
    hit = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && way_valid[s][i] && way_tag[s][i] == t) begin
        promote_way(s, i);
        hit = 1'b1;
      end
    end
    if (hit) begin
      hit_sum++;
    end else begin
      miss_sum++;
      victim = 0;
      found  = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
        if (!found && !way_valid[s][i]) begin
          victim = i;
          found  = 1'b1;
        end
      end
      if (!found) begin
        for (int i = 0; i < WAYS; i++) begin
          if (way_age[s][i] == rank_t'(WAYS - 1)) victim = i;
        end
        evict_sum++;
        ev = 1'b1;
      end
      way_valid[s][victim] = 1'b1;
      way_tag[s][victim]   = t;
      promote_way(s, victim);
    end
  endtask

  always @(posedge clk) begin
    access_outcome_t want;
    logic            second_hit;
    int              s;
    tag_t            t;
    if (rst) begin
      for (int i = 0; i < NUM_SETS; i++) begin
        for (int w = 0; w < WAYS; w++) begin
          way_valid[i][w] = 1'b0;
          way_tag[i][w]   = '0;
          way_age[i][w]   = rank_t'(w);
        end
      end
      hit_sum   = '0;
      miss_sum  = '0;
      evict_sum = '0;
      outcome_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result transfer with no access outstanding");
        end else begin
          want = outcome_q.pop_front();
          if (res.first_hit !== want.first_hit)
            report_mismatch($sformatf("first_hit got %b expected %b",
                                      res.first_hit, want.first_hit));
          if (res.evicted !== want.evicted)
            report_mismatch($sformatf("evicted got %b expected %b",
                                      res.evicted, want.evicted));
          if (res.hits_total !== want.hits)
            report_mismatch($sformatf("hits_total got %0d expected %0d",
                                      res.hits_total, want.hits));
          if (res.misses_total !== want.misses)
            report_mismatch($sformatf("misses_total got %0d expected %0d",
                                      res.misses_total, want.misses));
          if (res.evictions_total !== want.evicts)
            report_mismatch($sformatf("evictions_total got %0d expected %0d",
                                      res.evictions_total, want.evicts));
        end
      end
      if (acc.valid && acc.ready) begin
        s = int'((acc.address >> OFFSET_BITS) & ADDR_W'(NUM_SETS - 1));
        t = tag_t'(acc.address >> (SET_BITS + OFFSET_BITS));
        want.evicted = 1'b0;
        lookup_way(t, s, want.first_hit, want.evicted);
        // The second half of a modify always finds the line again.
        if (acc.kind == KIND_MODIFY) lookup_way(t, s, second_hit, want.evicted);
        want.hits   = hit_sum;
        want.misses = miss_sum;
        want.evicts = evict_sum;
        outcome_q.push_back(want);
      end
    end
    fail_count  <= mismatches;
    outstanding <= outcome_q.size();
  end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none

// Top of the cache tag store test. It owns the clock, the one reset, the access
// stimulus and the result-side stalls; all prediction and comparison lives in the
// checker instance, which hands back its failure count and how many results are
// still outstanding.
module testbench;
  import salc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ACCESSES = 600;
  localparam int TAG_POOL        = 6;
  // Each access needs its read and its update plus stalls on both sides; this is many times that.
  localparam int CYCLE_LIMIT     = 200_000;
  localparam int DRAIN_CYCLES    = 16;

  logic        clk;
  logic        rst;
  // While steady is high neither side inserts idle cycles.
  logic        steady;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count;

  salc_in_if  acc_ch ();
  salc_out_if res_ch ();

  set_assoc_lru_cache_tags u_dut (
    .clk (clk),
    .rst (rst),
    .acc (acc_ch),
    .res (res_ch)
  );

  salc_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .acc         (acc_ch),
    .res         (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hang anywhere, including results that never arrive, ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("set_assoc_lru_cache_tags test failed");
      $finish;
    end
  end

  // Result side: the sink drops ready about ten percent of the time unless steady.
  always @(negedge clk) begin
    res_ch.ready <= (!steady && $urandom_range(0, 99) < 10) ? 1'b0 : 1'b1;
  end

  // Builds a byte address from its tag, set index and block offset.
  function automatic logic [ADDR_W-1:0] line_addr(input tag_t t, input int s, input int off);
    return (ADDR_W'(t) << (SET_BITS + OFFSET_BITS)) | (ADDR_W'(s) << OFFSET_BITS) |
           ADDR_W'(off);
  endfunction

  // Offers one access and returns on the falling edge after its transfer. Idle cycles
  // are put in front of the access, so gaps land on every phase of the block's work.
  // Valid stays high from one access to the next when no gap is drawn.
  task automatic send_access(input logic k, input logic [ADDR_W-1:0] a);
    while (!steady && $urandom_range(0, 99) < 10) begin
      acc_ch.valid <= 1'b0;
      @(negedge clk);
    end
    acc_ch.valid   <= 1'b1;
    acc_ch.kind    <= k;
    acc_ch.address <= a;
    @(posedge clk);
    while (!acc_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    tag_t        tag_pool [TAG_POOL];
    logic        k;
    logic [ADDR_W-1:0] a;

    rst            = 1'b1;
    steady         = 1'b0;
    cycle_count    = 0;
    acc_ch.valid   = 1'b0;
    acc_ch.kind    = KIND_SINGLE;
    acc_ch.address = '0;
    res_ch.ready   = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Set 0 is filled way by way from reset, so the lowest invalid
    // way is taken first; then the least recent line is pushed out, including after
    // a hit has reordered the set and by the first half of a modify.
    send_access(KIND_SINGLE, line_addr(tag_t'(0), 0, 0));
    send_access(KIND_SINGLE, line_addr(tag_t'(0), 0, (1 << OFFSET_BITS) - 1));
    send_access(KIND_MODIFY, line_addr(tag_t'(1), 0, 0));
    send_access(KIND_SINGLE, line_addr(tag_t'(2), 0, 0));
    send_access(KIND_SINGLE, line_addr(tag_t'(3), 0, 0));
    send_access(KIND_SINGLE, line_addr(tag_t'(0), 0, 8));
    send_access(KIND_SINGLE, line_addr(tag_t'(4), 0, 0));
    send_access(KIND_SINGLE, line_addr(tag_t'(1), 0, 0));
    send_access(KIND_MODIFY, line_addr(tag_t'(5), 0, 0));
    send_access(KIND_MODIFY, line_addr(tag_t'(5), 0, 3));
    // Address extremes: all ones lands in the last set with the largest tag.
    send_access(KIND_SINGLE, {ADDR_W{1'b1}});
    send_access(KIND_MODIFY, {ADDR_W{1'b1}});
    send_access(KIND_SINGLE, {1'b1, {(ADDR_W-1){1'b0}}});
    send_access(KIND_SINGLE, line_addr(tag_t'(0), 1, 0));
    send_access(KIND_SINGLE, line_addr(tag_t'(0), 2, 0));
    send_access(KIND_SINGLE, {(ADDR_W/4){4'hA}});
    send_access(KIND_MODIFY, {(ADDR_W/4){4'h5}});
    send_access(KIND_SINGLE, '0);

    // Random part. Most accesses draw their tag from a small pool so sets fill,
    // hit and evict often; the rest are fully random addresses. The middle stretch
    // runs with no idle cycles on either side.
    foreach (tag_pool[i]) tag_pool[i] = tag_t'({$urandom, $urandom});
    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      steady = (n >= 250 && n < 400);
      if ($urandom_range(0, 49) == 0)
        tag_pool[$urandom_range(0, TAG_POOL - 1)] = tag_t'({$urandom, $urandom});
      k = ($urandom_range(0, 3) == 0) ? KIND_MODIFY : KIND_SINGLE;
      if ($urandom_range(0, 99) < 85)
        a = line_addr(tag_pool[$urandom_range(0, TAG_POOL - 1)],
                      $urandom_range(0, NUM_SETS - 1),
                      $urandom_range(0, (1 << OFFSET_BITS) - 1));
      else
        a = {$urandom, $urandom};
      send_access(k, a);
    end
    acc_ch.valid <= 1'b0;
    steady = 1'b0;

    // Drain: every predicted result must arrive before the watchdog fires.
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("set_assoc_lru_cache_tags test passed");
    end else begin
      $display("set_assoc_lru_cache_tags test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
